### src/twme_pkg.sv
// Shared types and constants for the ternary weight matrix multiply engine.
package twme_pkg;

  localparam int ADDR_W     = 12;
  localparam int ADDR_SPAN  = 4096;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  // row * K + k stays below 16 * 512
  localparam int CUR_W      = 13;
  localparam int LANES      = 4;

  localparam logic [1:0] OP_LOAD_ACT = 2'd0;
  localparam logic [1:0] OP_LOAD_WGT = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_REDUCTION_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT        = 2'd2;

  localparam logic [8:0] RST_REDUCTION_LENGTH = 9'd256;
  localparam logic [4:0] RST_ROW_COUNT        = 5'd16;
  localparam logic [4:0] RST_COL_COUNT        = 5'd16;

  localparam logic [1:0] CODE_MASK = 2'b11;
  localparam logic [1:0] CODE_POS  = 2'b01;
  localparam logic [1:0] CODE_NEG  = 2'b11;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [7:0]  data;
    logic [3:0]  row;
    logic [3:0]  col;
  } req_t;

  typedef struct packed {
    logic signed [16:0] dot_sum;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic               error;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic is_compute;
    logic skip;
    logic last;
    logic pipe_empty;
  } sts_t;

endpackage

### src/twme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/twme_ctrl.sv
// Controller: runs one compute through issue, drain (or skip) and publish.
module twme_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  twme_pkg::sts_t    sts,
  output twme_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    ISSUE,
    DRAIN,
    FINISH
  } state_t;

  state_t state;

  always_comb begin
    req_ready   = (state == IDLE);
    cmd.accept  = req_valid && req_ready;
    cmd.issue   = (state == ISSUE);
    cmd.publish = (state == FINISH) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          // loads finish in the accept cycle; only a compute leaves idle
          if (cmd.accept && sts.is_compute) begin
            state <= sts.skip ? FINISH : ISSUE;
          end
        end
        ISSUE: begin
          if (sts.last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (sts.pipe_empty) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          // hold until the output register is free
          if (cmd.publish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### src/twme_dpath.sv
// Datapath: config registers, banked stores, address walk, ternary accumulate, result register.
module twme_dpath #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_DEPTH = 256,
  parameter int MAX_COLS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [twme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twme_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  twme_pkg::req_t                       req,
  input  twme_pkg::cmd_t                       cmd,
  output twme_pkg::sts_t                       sts,
  output twme_pkg::rsp_t                       rsp
);

  localparam int ACT_FULL   = MAX_ROWS * MAX_DEPTH;
  localparam int ACT_DEPTH  = (ACT_FULL > twme_pkg::ADDR_SPAN) ? twme_pkg::ADDR_SPAN : ACT_FULL;
  localparam int BANK_DEPTH = (ACT_DEPTH + twme_pkg::LANES - 1) / twme_pkg::LANES;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int WGT_FULL   = ((MAX_DEPTH + twme_pkg::LANES - 1) / twme_pkg::LANES) * MAX_COLS;
  localparam int WGT_DEPTH  = (WGT_FULL > twme_pkg::ADDR_SPAN) ? twme_pkg::ADDR_SPAN : WGT_FULL;
  localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int K_CAP_I    = (MAX_DEPTH > 511) ? 511 : MAX_DEPTH;
  localparam int M_CAP_I    = (MAX_ROWS > 31) ? 31 : MAX_ROWS;
  localparam int N_CAP_I    = (MAX_COLS > 31) ? 31 : MAX_COLS;

  localparam logic [8:0]  K_CAP   = 9'(K_CAP_I);
  localparam logic [4:0]  M_CAP   = 5'(M_CAP_I);
  localparam logic [4:0]  N_CAP   = 5'(N_CAP_I);
  localparam logic [12:0] ACT_LIM = 13'(ACT_DEPTH);
  localparam logic [12:0] WGT_LIM = 13'(WGT_DEPTH);

  localparam int CW = twme_pkg::CUR_W;

  logic [8:0]  reduction_length;
  logic [4:0]  row_count;
  logic [4:0]  col_count;

  logic [8:0]  k_len;
  logic [4:0]  m_len;
  logic [4:0]  n_len;
  logic        err_req;
  logic        start;
  logic [CW-1:0] base;

  logic [CW-1:0] cur;
  logic [11:0]   waddr_cur;
  logic [8:0]    rem;
  logic [3:0]    lane_ok;
  logic          err_r;
  logic [3:0]    row_r;
  logic [3:0]    col_r;
  logic [16:0]   acc;

  logic          s1_valid;
  logic [1:0]    s1_rot;
  logic [3:0]    s1_mask;
  logic          s2_valid;
  logic signed [10:0] s2_part;
  logic signed [10:0] part;

  logic [7:0]    bank_rd [twme_pkg::LANES];
  logic [7:0]    wgt_rd;
  logic          act_load;
  logic          wgt_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduction_length <= twme_pkg::RST_REDUCTION_LENGTH;
      row_count        <= twme_pkg::RST_ROW_COUNT;
      col_count        <= twme_pkg::RST_COL_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        twme_pkg::REG_REDUCTION_LENGTH: reduction_length <= cfg_data;
        twme_pkg::REG_ROW_COUNT:        row_count        <= cfg_data[4:0];
        twme_pkg::REG_COL_COUNT:        col_count        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k_len   = (reduction_length > K_CAP) ? K_CAP : reduction_length;
    m_len   = (row_count > M_CAP) ? M_CAP : row_count;
    n_len   = (col_count > N_CAP) ? N_CAP : col_count;
    err_req = ({1'b0, req.row} >= m_len) || ({1'b0, req.col} >= n_len);
    base    = {{(CW - 4){1'b0}}, req.row} * {{(CW - 9){1'b0}}, k_len};
    start   = cmd.accept && (req.operation == twme_pkg::OP_COMPUTE);
    for (int j = 0; j < twme_pkg::LANES; j++) begin
      lane_ok[j] = (rem > 9'(j));
    end
    act_load = cmd.accept && (req.operation == twme_pkg::OP_LOAD_ACT)
               && ({1'b0, req.address} < ACT_LIM);
    wgt_load = cmd.accept && (req.operation == twme_pkg::OP_LOAD_WGT)
               && ({1'b0, req.address} < WGT_LIM);

    sts.is_compute = (req.operation == twme_pkg::OP_COMPUTE);
    sts.skip       = err_req || (k_len == 9'd0);
    sts.last       = (rem <= 9'd4);
    sts.pipe_empty = !s1_valid && !s2_valid;
  end

  // Four activation banks interleaved on the low address bits, so four
  // consecutive k land in four different banks.
  for (genvar b = 0; b < twme_pkg::LANES; b++) begin : g_bank
    logic [1:0]    off;
    logic [CW-1:0] lane_addr;

    always_comb begin
      off       = 2'(b) - cur[1:0];
      lane_addr = cur + {{(CW - 2){1'b0}}, off};
    end

    twme_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW)
    ) u_act (
      .clk   (clk),
      .we    (act_load && (req.address[1:0] == 2'(b))),
      .waddr (req.address[BANK_AW+1:2]),
      .wdata (req.data),
      .raddr (lane_addr[BANK_AW+1:2]),
      .rdata (bank_rd[b])
    );
  end

  twme_ram #(
    .WIDTH (8),
    .DEPTH (WGT_DEPTH),
    .AW    (WGT_AW)
  ) u_wgt (
    .clk   (clk),
    .we    (wgt_load),
    .waddr (req.address[WGT_AW-1:0]),
    .wdata (req.data),
    .raddr (waddr_cur[WGT_AW-1:0]),
    .rdata (wgt_rd)
  );

  // Rotate banks back to lane order and sum the four ternary terms.
  always_comb begin
    logic [1:0]        sel;
    logic [7:0]        act_b;
    logic [1:0]        code;
    logic signed [8:0] term;
    part = '0;
    for (int j = 0; j < twme_pkg::LANES; j++) begin
      sel   = s1_rot + 2'(j);
      act_b = bank_rd[sel];
      code  = 2'(wgt_rd >> (2 * j)) & twme_pkg::CODE_MASK;
      term  = '0;
      if (s1_mask[j]) begin
        case (code)
          twme_pkg::CODE_POS: term = {act_b[7], act_b};
          twme_pkg::CODE_NEG: term = -{act_b[7], act_b};
          default:            term = '0;
        endcase
      end
      part = part + {{2{term[8]}}, term};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur       <= base;
      waddr_cur <= {8'd0, req.col};
      rem       <= k_len;
      err_r     <= err_req;
      row_r     <= req.row;
      col_r     <= req.col;
    end else if (cmd.issue) begin
      // advance one packed weight byte: four k, one weight row of stride N
      cur       <= cur + CW'(twme_pkg::LANES);
      waddr_cur <= waddr_cur + {7'd0, n_len};
      rem       <= rem - 9'd4;
    end
    s1_rot  <= cur[1:0];
    s1_mask <= lane_ok;
    s2_part <= part;
    if (start) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + {{6{s2_part[10]}}, s2_part};
    end
    if (cmd.publish) begin
      rsp.dot_sum <= acc;
      rsp.out_row <= row_r;
      rsp.out_col <= col_r;
      rsp.error   <= err_r;
    end
  end

endmodule

### src/ternary_weight_matmul_engine.sv
// Load beats give no result; the next beat follows at once.
// A compute walks ceil(K/4) packed weight bytes, four activation-weight pairs a cycle
// (four activation banks plus one weight port); its result is published once the pipe
// drains and the output register is free, and the next beat is taken as it becomes valid.
// An out-of-range row/col or K=0 skips issue and drain and goes straight to publish.
// Synchronous reset sets K=256, M=16, N=16 and empties control; stores are not cleared.
module ternary_weight_matmul_engine #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_DEPTH = 256,
  parameter int MAX_COLS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [twme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [twme_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  twme_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output twme_pkg::rsp_t                    rsp
);

  twme_pkg::cmd_t cmd;
  twme_pkg::sts_t sts;

  twme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  twme_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_COLS  (MAX_COLS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !cmd.accept)
    else $error("request beat accepted during a compute");

  a_publish_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!rsp_valid || rsp_ready))
    else $error("result overwrote a pending beat");

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> rsp_valid)
    else $error("published result not presented");

  a_error_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.error) |-> (rsp.dot_sum == 17'sd0))
    else $error("error result with nonzero sum");

endmodule
